// ----- hdl/pish_pkg.sv -----
// Shared types, widths and codes for the point-in-shape hit test.
package pish_pkg;

   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = COORD_BITS - 1;
   localparam int KIND_BITS  = 3;

   // pipeline depth, output register included
   localparam int STAGES = 5;

   // signed difference of two coordinates and its magnitude
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int MAG_BITS   = COORD_BITS;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;
   localparam int RAD2_BITS  = 2 * SIZE_BITS;

   // ellipse: squared radius is at most 2^(2*COORD_BITS-2)
   localparam int AX2_BITS   = 2 * MAG_BITS - 1;
   localparam int ELL_BITS   = 2 * SQ_BITS;

   // line: cross product, its magnitude and the split square
   localparam int CROSS_BITS = 2 * DIFF_BITS;
   localparam int CDIFF_BITS = CROSS_BITS + 1;
   localparam int CMAG_BITS  = 2 * MAG_BITS + 1;
   localparam int LO_BITS    = (CMAG_BITS + 1) / 2;
   localparam int HI_BITS    = CMAG_BITS - LO_BITS;
   localparam int HH_BITS    = 2 * HI_BITS;
   localparam int HL_BITS    = HI_BITS + LO_BITS;
   localparam int LL_BITS    = 2 * LO_BITS;
   localparam int CSQ_BITS   = 2 * CMAG_BITS;
   localparam int LEN2_BITS  = SQ_BITS + 1;
   localparam int TOL_BITS   = RAD2_BITS + LEN2_BITS;

   // rounded rectangle: corner offsets reach beyond a plain difference
   localparam int RR_BITS    = COORD_BITS + 2;
   localparam int RMAG_BITS  = COORD_BITS + 1;
   localparam int RSQ_BITS   = 2 * RMAG_BITS;
   localparam int RSUM_BITS  = RSQ_BITS + 1;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_CIRCLE  = 3'd0,
      KIND_ELLIPSE = 3'd1,
      KIND_RECT    = 3'd2,
      KIND_RRECT   = 3'd3,
      KIND_LINE    = 3'd4
   } kind_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]         kind;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] ref_x;
      logic signed [COORD_BITS-1:0] ref_y;
      logic signed [COORD_BITS-1:0] far_x;
      logic signed [COORD_BITS-1:0] far_y;
      logic [SIZE_BITS-1:0]         size;
   } req_type;

   typedef struct packed {
      logic hit;
      logic degenerate;
   } rsp_type;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } pipe_ctrl_type;

endpackage

// ----- hdl/pish_pipe_ctrl.sv -----
// Valid bits and per-stage load enables of the hit test pipeline.
module pish_pipe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pish_pkg::pipe_ctrl_type ctrl
);
   import pish_pkg::*;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] load;

   // a stage loads when empty or when the stage after it loads
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = load[0];
   assign rsp_valid = valid_ff[STAGES-1];
   assign ctrl.load = load;

   // items in flight change only by what enters and leaves
   a_item_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         $countones(valid_ff) == $past($countones(valid_ff))
            + $past(req_valid && req_ready) - $past(rsp_valid && rsp_ready))
      else $error("pipeline item count mismatch");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted item not in first stage");

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

endmodule

// ----- hdl/point_in_shape_hit_test.sv -----
// Point-in-shape hit test: five-stage pipeline, one result item per request item.
// An accepted item moves through stages s1 to s5 in order; rsp_valid is the valid bit of s5.
// Throughput: one item per cycle while rsp_ready holds; each stage holds one item and moves on its own.
// A stalled output holds its item while earlier stages keep filling bubbles.
// Reset clears the stage valid bits only; the datapath registers are not reset.
module point_in_shape_hit_test (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pish_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pish_pkg::rsp_type rsp_data
);
   import pish_pkg::*;

   // Stage map:
   //   s1  differences, magnitudes, corner ordering, rectangle test, degenerate flag
   //   s2  single-width squares and cross terms, rounded band test, corner offsets
   //   s3  circle compare, ellipse products, cross difference, corner squares
   //   s4  ellipse compare, split square of the cross term, line tolerance, corners
   //   s5  line compare, kind select, output register

   function automatic logic [SQ_BITS-1:0] dsq(input logic signed [DIFF_BITS-1:0] v);
      logic [MAG_BITS-1:0] m;
      m = v[DIFF_BITS-1] ? MAG_BITS'(-v) : MAG_BITS'(v);
      return SQ_BITS'(m) * SQ_BITS'(m);
   endfunction

   function automatic logic [RSQ_BITS-1:0] rsq(input logic signed [RR_BITS-1:0] v);
      logic [RMAG_BITS-1:0] m;
      m = v[RR_BITS-1] ? RMAG_BITS'(-v) : RMAG_BITS'(v);
      return RSQ_BITS'(m) * RSQ_BITS'(m);
   endfunction

   pipe_ctrl_type ctrl;

   pish_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   // ---------------- stage 1 ----------------
   logic signed [DIFF_BITS-1:0]  px_e, py_e, rx_e, ry_e, fx_e, fy_e;
   logic [MAG_BITS-1:0]          s1_ax_in, s1_ay_in;
   logic                         s1_rect_in, s1_degen_in;
   logic signed [COORD_BITS-1:0] s1_x1_in, s1_x2_in, s1_y1_in, s1_y2_in;

   logic [KIND_BITS-1:0]         s1_kind_ff;
   logic signed [DIFF_BITS-1:0]  s1_dx_ff, s1_dy_ff, s1_ldx_ff, s1_ldy_ff;
   logic [MAG_BITS-1:0]          s1_ax_ff, s1_ay_ff;
   logic signed [COORD_BITS-1:0] s1_x1_ff, s1_x2_ff, s1_y1_ff, s1_y2_ff;
   logic signed [COORD_BITS-1:0] s1_px_ff, s1_py_ff;
   logic [SIZE_BITS-1:0]         s1_size_ff;
   logic                         s1_rect_ff, s1_degen_ff;

   assign px_e = DIFF_BITS'(req_data.point_x);
   assign py_e = DIFF_BITS'(req_data.point_y);
   assign rx_e = DIFF_BITS'(req_data.ref_x);
   assign ry_e = DIFF_BITS'(req_data.ref_y);
   assign fx_e = DIFF_BITS'(req_data.far_x);
   assign fy_e = DIFF_BITS'(req_data.far_y);

   always_comb begin
      // ellipse radii: only the magnitude matters
      s1_ax_in = fx_e[DIFF_BITS-1] ? MAG_BITS'(-fx_e) : MAG_BITS'(fx_e);
      s1_ay_in = fy_e[DIFF_BITS-1] ? MAG_BITS'(-fy_e) : MAG_BITS'(fy_e);

      // plain rectangle, both bounds inclusive; negative extent misses
      s1_rect_in = (px_e >= rx_e) && (px_e <= rx_e + fx_e) &&
                   (py_e >= ry_e) && (py_e <= ry_e + fy_e);

      // rounded rectangle corners in ascending order
      if (req_data.ref_x > req_data.far_x) begin
         s1_x1_in = req_data.far_x;
         s1_x2_in = req_data.ref_x;
      end else begin
         s1_x1_in = req_data.ref_x;
         s1_x2_in = req_data.far_x;
      end
      if (req_data.ref_y > req_data.far_y) begin
         s1_y1_in = req_data.far_y;
         s1_y2_in = req_data.ref_y;
      end else begin
         s1_y1_in = req_data.ref_y;
         s1_y2_in = req_data.far_y;
      end

      unique case (req_data.kind)
         KIND_ELLIPSE: begin
            s1_degen_in = (req_data.far_x == '0) || (req_data.far_y == '0);
         end
         KIND_LINE: begin
            s1_degen_in = (req_data.far_x == req_data.ref_x) &&
                          (req_data.far_y == req_data.ref_y);
         end
         default: begin
            s1_degen_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s1_kind_ff  <= req_data.kind;
         s1_dx_ff    <= px_e - rx_e;
         s1_dy_ff    <= py_e - ry_e;
         s1_ldx_ff   <= fx_e - rx_e;
         s1_ldy_ff   <= fy_e - ry_e;
         s1_ax_ff    <= s1_ax_in;
         s1_ay_ff    <= s1_ay_in;
         s1_x1_ff    <= s1_x1_in;
         s1_x2_ff    <= s1_x2_in;
         s1_y1_ff    <= s1_y1_in;
         s1_y2_ff    <= s1_y2_in;
         s1_px_ff    <= req_data.point_x;
         s1_py_ff    <= req_data.point_y;
         s1_size_ff  <= req_data.size;
         s1_rect_ff  <= s1_rect_in;
         s1_degen_ff <= s1_degen_in;
      end
   end

   // ---------------- stage 2 ----------------
   logic signed [RR_BITS-1:0]    r_e, x1_e, x2_e, y1_e, y2_e, pxr_e, pyr_e;
   logic signed [RR_BITS-1:0]    xlo, xhi, ylo, yhi;
   logic                         s2_band_in;

   logic [KIND_BITS-1:0]         s2_kind_ff;
   logic [SQ_BITS-1:0]           s2_dx2_ff, s2_dy2_ff, s2_ax2_ff, s2_ay2_ff;
   logic [SQ_BITS-1:0]           s2_lx2_ff, s2_ly2_ff;
   logic [RAD2_BITS-1:0]         s2_sz2_ff;
   logic signed [CROSS_BITS-1:0] s2_p1_ff, s2_p2_ff;
   logic signed [RR_BITS-1:0]    s2_cxa_ff, s2_cxb_ff, s2_cya_ff, s2_cyb_ff;
   logic                         s2_band_ff, s2_rect_ff, s2_degen_ff;

   always_comb begin
      r_e   = $signed(RR_BITS'(s1_size_ff));
      x1_e  = RR_BITS'(s1_x1_ff);
      x2_e  = RR_BITS'(s1_x2_ff);
      y1_e  = RR_BITS'(s1_y1_ff);
      y2_e  = RR_BITS'(s1_y2_ff);
      pxr_e = RR_BITS'(s1_px_ff);
      pyr_e = RR_BITS'(s1_py_ff);
      // corner circle centers
      xlo   = x1_e + r_e;
      xhi   = x2_e - r_e;
      ylo   = y1_e + r_e;
      yhi   = y2_e - r_e;
      // horizontal band or vertical band
      s2_band_in = ((pxr_e >= xlo) && (pxr_e <= xhi) &&
                    (pyr_e >= y1_e) && (pyr_e <= y2_e)) ||
                   ((pxr_e >= x1_e) && (pxr_e <= x2_e) &&
                    (pyr_e >= ylo) && (pyr_e <= yhi));
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         s2_kind_ff  <= s1_kind_ff;
         s2_dx2_ff   <= dsq(s1_dx_ff);
         s2_dy2_ff   <= dsq(s1_dy_ff);
         s2_ax2_ff   <= SQ_BITS'(s1_ax_ff) * SQ_BITS'(s1_ax_ff);
         s2_ay2_ff   <= SQ_BITS'(s1_ay_ff) * SQ_BITS'(s1_ay_ff);
         s2_lx2_ff   <= dsq(s1_ldx_ff);
         s2_ly2_ff   <= dsq(s1_ldy_ff);
         s2_sz2_ff   <= RAD2_BITS'(s1_size_ff) * RAD2_BITS'(s1_size_ff);
         s2_p1_ff    <= CROSS_BITS'(s1_ldy_ff) * CROSS_BITS'(s1_dx_ff);
         s2_p2_ff    <= CROSS_BITS'(s1_ldx_ff) * CROSS_BITS'(s1_dy_ff);
         s2_cxa_ff   <= pxr_e - xlo;
         s2_cxb_ff   <= pxr_e - xhi;
         s2_cya_ff   <= pyr_e - ylo;
         s2_cyb_ff   <= pyr_e - yhi;
         s2_band_ff  <= s2_band_in;
         s2_rect_ff  <= s1_rect_ff;
         s2_degen_ff <= s1_degen_ff;
      end
   end

   // ---------------- stage 3 ----------------
   logic signed [CDIFF_BITS-1:0] cross_diff;
   logic [CMAG_BITS-1:0]         s3_cm_in;
   logic                         s3_circ_in;

   logic [KIND_BITS-1:0]         s3_kind_ff;
   logic [ELL_BITS-1:0]          s3_m1_ff, s3_m2_ff, s3_rhs_ff;
   logic [CMAG_BITS-1:0]         s3_cm_ff;
   logic [LEN2_BITS-1:0]         s3_len2_ff;
   logic [RAD2_BITS-1:0]         s3_sz2_ff;
   logic [RSQ_BITS-1:0]          s3_xa2_ff, s3_xb2_ff, s3_ya2_ff, s3_yb2_ff;
   logic                         s3_circ_ff, s3_band_ff, s3_rect_ff, s3_degen_ff;

   always_comb begin
      s3_circ_in = (SUM_BITS'(s2_dx2_ff) + SUM_BITS'(s2_dy2_ff)) <= SUM_BITS'(s2_sz2_ff);
      cross_diff = CDIFF_BITS'(s2_p1_ff) - CDIFF_BITS'(s2_p2_ff);
      s3_cm_in   = cross_diff[CDIFF_BITS-1] ? CMAG_BITS'(-cross_diff)
                                            : CMAG_BITS'(cross_diff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         s3_kind_ff  <= s2_kind_ff;
         s3_m1_ff    <= ELL_BITS'(s2_dx2_ff) * ELL_BITS'(s2_ay2_ff[AX2_BITS-1:0]);
         s3_m2_ff    <= ELL_BITS'(s2_dy2_ff) * ELL_BITS'(s2_ax2_ff[AX2_BITS-1:0]);
         s3_rhs_ff   <= ELL_BITS'(s2_ax2_ff[AX2_BITS-1:0]) *
                        ELL_BITS'(s2_ay2_ff[AX2_BITS-1:0]);
         s3_cm_ff    <= s3_cm_in;
         s3_len2_ff  <= LEN2_BITS'(s2_lx2_ff) + LEN2_BITS'(s2_ly2_ff);
         s3_sz2_ff   <= s2_sz2_ff;
         s3_xa2_ff   <= rsq(s2_cxa_ff);
         s3_xb2_ff   <= rsq(s2_cxb_ff);
         s3_ya2_ff   <= rsq(s2_cya_ff);
         s3_yb2_ff   <= rsq(s2_cyb_ff);
         s3_circ_ff  <= s3_circ_in;
         s3_band_ff  <= s2_band_ff;
         s3_rect_ff  <= s2_rect_ff;
         s3_degen_ff <= s2_degen_ff;
      end
   end

   // ---------------- stage 4 ----------------
   logic [HI_BITS-1:0]   cm_hi;
   logic [LO_BITS-1:0]   cm_lo;
   logic [RSUM_BITS-1:0] r2_e;
   logic                 s4_ell_in, s4_rrect_in;

   logic [KIND_BITS-1:0] s4_kind_ff;
   logic [HH_BITS-1:0]   s4_hh_ff;
   logic [HL_BITS-1:0]   s4_hl_ff;
   logic [LL_BITS-1:0]   s4_ll_ff;
   logic [TOL_BITS-1:0]  s4_tol_ff;
   logic                 s4_ell_ff, s4_rrect_ff, s4_circ_ff, s4_rect_ff, s4_degen_ff;

   always_comb begin
      s4_ell_in = (s3_m1_ff + s3_m2_ff) <= s3_rhs_ff;
      cm_hi     = s3_cm_ff[CMAG_BITS-1:LO_BITS];
      cm_lo     = s3_cm_ff[LO_BITS-1:0];
      r2_e      = RSUM_BITS'(s3_sz2_ff);
      s4_rrect_in = s3_band_ff ||
         ((RSUM_BITS'(s3_xa2_ff) + RSUM_BITS'(s3_ya2_ff)) <= r2_e) ||
         ((RSUM_BITS'(s3_xb2_ff) + RSUM_BITS'(s3_ya2_ff)) <= r2_e) ||
         ((RSUM_BITS'(s3_xa2_ff) + RSUM_BITS'(s3_yb2_ff)) <= r2_e) ||
         ((RSUM_BITS'(s3_xb2_ff) + RSUM_BITS'(s3_yb2_ff)) <= r2_e);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         s4_kind_ff  <= s3_kind_ff;
         s4_hh_ff    <= HH_BITS'(cm_hi) * HH_BITS'(cm_hi);
         s4_hl_ff    <= HL_BITS'(cm_hi) * HL_BITS'(cm_lo);
         s4_ll_ff    <= LL_BITS'(cm_lo) * LL_BITS'(cm_lo);
         s4_tol_ff   <= TOL_BITS'(s3_sz2_ff) * TOL_BITS'(s3_len2_ff);
         s4_ell_ff   <= s4_ell_in;
         s4_rrect_ff <= s4_rrect_in;
         s4_circ_ff  <= s3_circ_ff;
         s4_rect_ff  <= s3_rect_ff;
         s4_degen_ff <= s3_degen_ff;
      end
   end

   // ---------------- stage 5: output register ----------------
   logic [CSQ_BITS-1:0]  cross_sq;
   logic                 line_hit;
   rsp_type              rsp_in;
   rsp_type              rsp_ff;
   logic [KIND_BITS-1:0] s5_kind_ff;

   always_comb begin
      // (hi*2^L + lo)^2 = hh*2^2L + 2*hl*2^L + ll
      cross_sq = (CSQ_BITS'(s4_hh_ff) << (2 * LO_BITS)) +
                 (CSQ_BITS'(s4_hl_ff) << (LO_BITS + 1)) +
                 CSQ_BITS'(s4_ll_ff);
      line_hit = cross_sq <= CSQ_BITS'(s4_tol_ff);

      rsp_in.degenerate = s4_degen_ff;
      unique case (s4_kind_ff)
         KIND_CIRCLE: begin
            rsp_in.hit = s4_circ_ff;
         end
         KIND_ELLIPSE: begin
            rsp_in.hit = s4_ell_ff && !s4_degen_ff;
         end
         KIND_RECT: begin
            rsp_in.hit = s4_rect_ff;
         end
         KIND_RRECT: begin
            rsp_in.hit = s4_rrect_ff;
         end
         KIND_LINE: begin
            rsp_in.hit = line_hit && !s4_degen_ff;
         end
         default: begin
            rsp_in.hit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         rsp_ff     <= rsp_in;
         s5_kind_ff <= s4_kind_ff;
      end
   end

   assign rsp_data = rsp_ff;

   // a degenerate shape never reports a hit
   a_degen_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> !rsp_data.hit)
      else $error("degenerate item reported as hit");

   // only ellipse and line can be degenerate
   a_degen_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         (s5_kind_ff == KIND_ELLIPSE || s5_kind_ff == KIND_LINE))
      else $error("degenerate flag on wrong kind");

   // unused kinds give an empty result
   a_unused_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(s5_kind_ff == KIND_CIRCLE || s5_kind_ff == KIND_ELLIPSE ||
                     s5_kind_ff == KIND_RECT || s5_kind_ff == KIND_RRECT ||
                     s5_kind_ff == KIND_LINE)
         |-> !rsp_data.hit && !rsp_data.degenerate)
      else $error("unused kind produced a hit or degenerate flag");

endmodule
